### hw/rtl/adab_pkg.sv
`default_nettype none
package adab_pkg;

   // Relative velocity after saturation never needs more than 33 bits.
   localparam int DIFF_W = 33;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int ROOT_W = DIFF_W + 1;
   localparam int XY_W   = DIFF_W + 3;
   localparam int Z_W    = 34;

   localparam logic signed [Z_W-1:0] Q30_PI      = 34'sd3373259426;
   localparam logic signed [Z_W-1:0] Q30_HALF_PI = 34'sd1686629713;

   // atan(2^-i) in Q30, rounded to nearest.
   localparam logic signed [Z_W-1:0] ATAN_Q30 [32] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
      34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
      34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
      34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
      34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
      34'sd1024,      34'sd512,       34'sd256,       34'sd128,
      34'sd64,        34'sd32,        34'sd16,        34'sd8,
      34'sd4,         34'sd2,         34'sd1,         34'sd0
   };

   typedef struct packed {
      logic                   done;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_type;

endpackage
`default_nettype wire

### hw/rtl/adab_sqrt_step.sv
`default_nettype none
module adab_sqrt_step import adab_pkg::*; #(
   parameter int BIT = 0
) (
   input  wire logic [SQ_W-1:0]   rem_in_val,
   input  wire logic [ROOT_W-1:0] root_in_val,
   output logic      [SQ_W-1:0]   rem_out_val,
   output logic      [ROOT_W-1:0] root_out_val
);
   localparam int TW = SQ_W + 2;

   logic [TW-1:0] trial;
   logic [TW-1:0] rem_ext;

   // Setting this root bit grows the square by (root << (BIT+1)) + 4^BIT.
   always_comb begin
      trial   = (TW'(root_in_val) << (BIT + 1)) + (TW'(1) << (2 * BIT));
      rem_ext = TW'(rem_in_val);
      if (rem_ext >= trial) begin
         rem_out_val  = SQ_W'(rem_ext - trial);
         root_out_val = root_in_val | (ROOT_W'(1) << BIT);
      end else begin
         rem_out_val  = rem_in_val;
         root_out_val = root_in_val;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/adab_cordic_step.sv
`default_nettype none
module adab_cordic_step import adab_pkg::*; #(
   parameter int IDX = 0
) (
   input  wire cordic_type cin,
   output cordic_type      cout
);
   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;

   always_comb begin
      xs   = cin.x >>> IDX;
      ys   = cin.y >>> IDX;
      cout = cin;
      if (!cin.done) begin
         if (cin.y > 0) begin
            cout.x = cin.x + ys;
            cout.y = cin.y - xs;
            cout.z = cin.z + ATAN_Q30[IDX];
         end else begin
            cout.x = cin.x - ys;
            cout.y = cin.y + xs;
            cout.z = cin.z - ATAN_Q30[IDX];
         end
      end
   end
endmodule
`default_nettype wire

### hw/rtl/air_data_airspeed_alpha_beta.sv
`default_nettype none
// Air data pipeline: takes body velocity and wind (signed Q16.16), forms the
// saturated relative velocity, and returns airspeed (unsigned Q16.16, floor of
// the magnitude) with angle of attack and sideslip (signed, ANGLE_FRAC_BITS
// fraction bits). One item is accepted every cycle while the result side is not
// stalled. Stages: three front stages (difference, squares and CORDIC setup,
// sum), one stage per bit of the 34-bit root or per CORDIC iteration, whichever
// is more (the two run side by side), and an output rounding stage. A stall on
// the result side freezes the whole pipeline.
module air_data_airspeed_alpha_beta import adab_pkg::*; #(
   parameter int VEL_WIDTH       = 32,
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int CORDIC_STAGES   = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // vel_x, vel_y, vel_z, wind_x, wind_y, wind_z, 32 bits each
   input  wire logic [191:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // airspeed [31:0], attack_angle [47:32], sideslip_angle [63:48]
   output logic      [63:0]  rsp_tdata
);
   localparam int NI    = (CORDIC_STAGES > ROOT_W) ? CORDIC_STAGES : ROOT_W;
   localparam int SAT_W = (VEL_WIDTH < DIFF_W) ? VEL_WIDTH : DIFF_W;
   localparam longint LIM_L = (longint'(1) << (SAT_W - 1)) - 1;
   localparam logic signed [DIFF_W-1:0] LIM_HI = DIFF_W'(LIM_L);
   localparam logic signed [DIFF_W-1:0] LIM_LO = -LIM_HI - 1;
   localparam int SH = 30 - ANGLE_FRAC_BITS;

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   function automatic logic signed [DIFF_W-1:0] sat_diff(input logic [31:0] a,
                                                         input logic [31:0] b);
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'($signed(a)) - DIFF_W'($signed(b));
      if (d > LIM_HI) return LIM_HI;
      if (d < LIM_LO) return LIM_LO;
      return d;
   endfunction

   function automatic cordic_type cordic_init(input logic signed [DIFF_W-1:0] x,
                                              input logic signed [DIFF_W-1:0] y);
      cordic_type c;
      c.done = 1'b0;
      c.x    = XY_W'(x);
      c.y    = XY_W'(y);
      c.z    = '0;
      if (x == 0) begin
         c.done = 1'b1;
         if (y > 0) c.z = Q30_HALF_PI;
         else if (y < 0) c.z = -Q30_HALF_PI;
      end else if (y == 0) begin
         c.done = 1'b1;
         if (x < 0) c.z = Q30_PI;
      end else if (x < 0) begin
         c.z = (y > 0) ? Q30_PI : -Q30_PI;
         c.x = -c.x;
         c.y = -c.y;
      end
      return c;
   endfunction

   function automatic logic [15:0] round_angle(input logic signed [Z_W-1:0] z);
      logic [Z_W:0] mag;
      logic [Z_W:0] q;
      mag = z[Z_W-1] ? (Z_W+1)'(-z) : (Z_W+1)'(z);
      q   = (mag + ((Z_W+1)'(1) << (SH - 1))) >> SH;
      if (z[Z_W-1]) begin
         if (q > (Z_W+1)'(32768)) return 16'h8000;
         return 16'(-q);
      end
      if (q > (Z_W+1)'(32767)) return 16'h7FFF;
      return q[15:0];
   endfunction

   // Stage 0: relative velocity.
   logic                     v0_ff;
   logic signed [DIFF_W-1:0] u_ff, vv_ff, w_ff;
   // Stage 1: squares and CORDIC setup.
   logic                     v1_ff;
   logic [SQ_W-1:0]          squ_ff, sqv_ff, sqw_ff;
   cordic_type               ca1_ff, cb1_ff;
   // Iteration stages, index 0 is the sum stage.
   logic                     vi_ff   [NI+1];
   logic [SQ_W-1:0]          rem_ff  [NI+1];
   logic [ROOT_W-1:0]        root_ff [NI+1];
   cordic_type               ca_ff   [NI+1];
   cordic_type               cb_ff   [NI+1];
   // Output register.
   logic                     vo_ff;
   logic [63:0]              out_ff;

   logic [DIFF_W-1:0] au, av, aw;
   assign au = u_ff[DIFF_W-1]  ? DIFF_W'(-u_ff)  : DIFF_W'(u_ff);
   assign av = vv_ff[DIFF_W-1] ? DIFF_W'(-vv_ff) : DIFF_W'(vv_ff);
   assign aw = w_ff[DIFF_W-1]  ? DIFF_W'(-w_ff)  : DIFF_W'(w_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         vi_ff[0] <= 1'b0;
      end else if (en) begin
         v0_ff    <= req_tvalid;
         v1_ff    <= v0_ff;
         vi_ff[0] <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff       <= sat_diff(req_tdata[31:0],  req_tdata[127:96]);
         vv_ff      <= sat_diff(req_tdata[63:32], req_tdata[159:128]);
         w_ff       <= sat_diff(req_tdata[95:64], req_tdata[191:160]);
         squ_ff     <= SQ_W'(au) * SQ_W'(au);
         sqv_ff     <= SQ_W'(av) * SQ_W'(av);
         sqw_ff     <= SQ_W'(aw) * SQ_W'(aw);
         ca1_ff     <= cordic_init(u_ff, w_ff);
         cb1_ff     <= cordic_init(u_ff, vv_ff);
         rem_ff[0]  <= squ_ff + sqv_ff + sqw_ff;
         root_ff[0] <= '0;
         ca_ff[0]   <= ca1_ff;
         cb_ff[0]   <= cb1_ff;
      end
   end

   for (genvar k = 0; k < NI; k++) begin : g_iter
      logic [SQ_W-1:0]   rem_nx;
      logic [ROOT_W-1:0] root_nx;
      cordic_type        ca_nx, cb_nx;

      if (k < ROOT_W) begin : g_sqrt
         adab_sqrt_step #(.BIT(ROOT_W - 1 - k)) u_sqrt (
            .rem_in_val  (rem_ff[k]),
            .root_in_val (root_ff[k]),
            .rem_out_val (rem_nx),
            .root_out_val(root_nx)
         );
      end else begin : g_sqrt_hold
         assign rem_nx  = rem_ff[k];
         assign root_nx = root_ff[k];
      end

      if (k < CORDIC_STAGES) begin : g_cordic
         adab_cordic_step #(.IDX(k)) u_ca (.cin(ca_ff[k]), .cout(ca_nx));
         adab_cordic_step #(.IDX(k)) u_cb (.cin(cb_ff[k]), .cout(cb_nx));
      end else begin : g_cordic_hold
         assign ca_nx = ca_ff[k];
         assign cb_nx = cb_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vi_ff[k+1] <= 1'b0;
         end else if (en) begin
            vi_ff[k+1] <= vi_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_nx;
            root_ff[k+1] <= root_nx;
            ca_ff[k+1]   <= ca_nx;
            cb_ff[k+1]   <= cb_nx;
         end
      end
   end

   logic [31:0] speed_sat;
   assign speed_sat = (root_ff[NI] > ROOT_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                            : root_ff[NI][31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= vi_ff[NI];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= {round_angle(cb_ff[NI].z), round_angle(ca_ff[NI].z), speed_sat};
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = out_ff;
endmodule
`default_nettype wire

### tb/sv/adab_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module adab_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [191:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [63:0]  rsp_tdata,
   output int                fail_count,
   output int                pending
);

   localparam int FRAC   = 13;
   localparam int STAGES = 16;
   localparam longint PI_Q30   = 64'sd3373259426;
   localparam longint HALF_PI  = 64'sd1686629713;

   typedef struct packed {
      logic        [31:0] airspeed;
      logic signed [15:0] attack;
      logic signed [15:0] sideslip;
   } air_data_type;

   longint arctan_q30 [16] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768
   };

   air_data_type air_data_q [$];

   function automatic longint rel_axis(logic signed [31:0] a, logic signed [31:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < -64'sd2147483648) d = -64'sd2147483648;
      return d;
   endfunction

   function automatic logic [31:0] air_speed(longint u, longint v, longint w);
      logic [127:0] sum_sq, trial;
      logic [63:0]  root;
      logic [63:0]  ua, va, wa;
      ua = u < 0 ? -u : u;
      va = v < 0 ? -v : v;
      wa = w < 0 ? -w : w;
      sum_sq = 128'(ua * ua) + 128'(va * va) + 128'(wa * wa);
      root = 0;
      for (int b = 33; b >= 0; b--) begin
         trial = 128'(root | (64'd1 << b));
         if (trial * trial <= sum_sq) root = trial[63:0];
      end
      return root > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : root[31:0];
   endfunction

   function automatic logic signed [15:0] heading(longint x, longint y);
      longint z, xs, ys, mag, q;
      z = 0;
      if (x == 0 && y == 0) z = 0;
      else if (x == 0) z = y > 0 ? HALF_PI : -HALF_PI;
      else if (y == 0) z = x > 0 ? 0 : PI_Q30;
      else begin
         if (x < 0) begin
            z = y > 0 ? PI_Q30 : -PI_Q30;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x += ys; y -= xs; z += arctan_q30[i];
            end else begin
               x -= ys; y += xs; z -= arctan_q30[i];
            end
         end
      end
      mag = z < 0 ? -z : z;
      q = (mag + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
      if (z < 0) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   always @(posedge clock) begin
      longint u, v, w;
      air_data_type got, want, item;
      if (!reset && req_tvalid && req_tready) begin
         u = rel_axis(req_tdata[31:0], req_tdata[127:96]);
         v = rel_axis(req_tdata[63:32], req_tdata[159:128]);
         w = rel_axis(req_tdata[95:64], req_tdata[191:160]);
         item = '{air_speed(u, v, w), heading(u, w), heading(u, v)};
         air_data_q = {air_data_q, item};
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[31:0], rsp_tdata[47:32], rsp_tdata[63:48]};
         if (air_data_q.size() == 0) begin
            $error("unexpected item %h", rsp_tdata);
            fail_count++;
         end else begin
            want = air_data_q.pop_front();
            if (got.airspeed !== want.airspeed) begin
               $error("airspeed expected %h actual %h", want.airspeed, got.airspeed);
               fail_count++;
            end
            if (got.attack !== want.attack) begin
               $error("attack_angle expected %0d actual %0d", want.attack, got.attack);
               fail_count++;
            end
            if (got.sideslip !== want.sideslip) begin
               $error("sideslip_angle expected %0d actual %0d", want.sideslip,
                      got.sideslip);
               fail_count++;
            end
         end
      end
      pending = air_data_q.size();
   end

endmodule
`default_nettype wire

### tb/sv/tb_air_data_airspeed_alpha_beta.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_air_data_airspeed_alpha_beta;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 60;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [63:0]  rsp_tdata;
   int           fail_count, pending;
   int           send_idle_pct = 0, recv_stall_pct = 0;
   bit           hold_rsp = 0;
   int           quiet_cycles = 0;

   air_data_airspeed_alpha_beta u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   adab_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .fail_count, .pending
   );

   initial forever #5 clock = ~clock;

   // Receiver throttling, plus a long hold-off on request.
   always @(negedge clock) begin
      if (hold_rsp) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL air_data_airspeed_alpha_beta");
         $finish;
      end
   end

   function automatic logic [31:0] pick_field();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3: return $urandom_range(16'hFFFF) - 32'h8000;
         4: return $urandom_range(32'h0010_0000) << $urandom_range(12);
         default: return $urandom();
      endcase
   endfunction

   // The valid stays high from one item to the next; it drops only while idling.
   task automatic send_item(logic [31:0] vx, vy, vz, wx, wy, wz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {wz, wy, wx, vz, vy, vx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(int count);
      logic [31:0] f [6];
      for (int n = 0; n < count; n++) begin
         foreach (f[k]) f[k] = pick_field();
         // Zero some relative components to reach the axis cases.
         if ($urandom_range(9) == 0) f[3] = f[0];
         if ($urandom_range(9) == 0) f[4] = f[1];
         if ($urandom_range(9) == 0) f[5] = f[2];
         send_item(f[0], f[1], f[2], f[3], f[4], f[5]);
      end
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed: zeros, axes, each sign, saturation of differences.
      send_item(0, 0, 0, 0, 0, 0);
      send_item(32'h0001_0000, 0, 0, 0, 0, 0);
      send_item(32'hFFFF_0000, 0, 0, 0, 0, 0);
      send_item(0, 32'h0001_0000, 32'h0001_0000, 0, 0, 0);
      send_item(0, 32'hFFFF_0000, 32'hFFFF_0000, 0, 0, 0);
      send_item(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0);
      send_item(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0);
      send_item(32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 0, 0, 0);
      send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
      send_item(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0);
      send_item(32'hFFFF_FFFF, 0, 32'h0000_0001, 0, 0, 0);
      send_item(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9,
                32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_random(250);
      send_idle_pct = 56;
      send_random(250);
      send_idle_pct = 0;
      recv_stall_pct = 56;
      send_random(250);
      // Long hold-off on the result side while items keep coming.
      recv_stall_pct = 0;
      fork
         begin
            hold_rsp = 1;
            repeat (200) @(negedge clock);
            hold_rsp = 0;
         end
         send_random(120);
      join
      // Pause until the pipeline is empty.
      wait_drain();
      send_idle_pct = 10;
      recv_stall_pct = 10;
      send_random(250);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_random(80);
      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("PASS air_data_airspeed_alpha_beta");
      else $display("FAIL air_data_airspeed_alpha_beta");
      $finish;
   end

endmodule
`default_nettype wire

### air_data_airspeed_alpha_beta.f
hw/rtl/adab_pkg.sv
hw/rtl/adab_sqrt_step.sv
hw/rtl/adab_cordic_step.sv
hw/rtl/air_data_airspeed_alpha_beta.sv
tb/sv/adab_checker.sv
tb/sv/tb_air_data_airspeed_alpha_beta.sv
